// File: rtl/adeq_pkg.sv
`timescale 1ns / 1ps
package adeq_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

   localparam int DATA_W = 32;

   localparam logic [1:0] MODE_PUSH_BACK  = 2'd0;
   localparam logic [1:0] MODE_PUSH_FRONT = 2'd1;
   localparam logic [1:0] MODE_POP_FRONT  = 2'd2;
   localparam logic [1:0] MODE_POP_BACK   = 2'd3;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   // command from the controller to the cell row and the response path
   typedef struct packed {
      logic             shift;
      logic             write;
      logic [IDX_W-1:0] wr_idx;
      logic [IDX_W-1:0] rd_idx;
      logic             pop_ok;
      logic [1:0]       status;
   } cmd_type;

endpackage

// File: rtl/array_double_ended_queue_unit.sv
`timescale 1ns / 1ps
// Response: a response beat turns valid in the cycle after its request beat is taken.
// Throughput: one beat per cycle while no response stall holds req_tready low;
//   any operation, even a front push moving all entries up, takes one row pass.
// Reset: synchronous, active high; clears head, tail, empty flag and the
//   response valid flag. Cell contents are not cleared and need no sweep.
module array_double_ended_queue_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [1:0]  req_tuser,   // [1:0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] popped_value
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   adeq_pkg::cmd_type           cmd;
   logic                        fire;
   logic [adeq_pkg::DATA_W-1:0] cell_q [adeq_pkg::DEPTH];
   logic [adeq_pkg::DATA_W-1:0] rd_data;

   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic [1:0]                  rsp_status_ff;
   logic [adeq_pkg::DATA_W-1:0] rsp_data_ff;

   // Take a new beat whenever the response register is free or draining.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign fire       = req_tvalid && req_tready;

   adeq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .mode  (req_tuser),
      .cmd   (cmd)
   );

   // Row of storage cells: on a shift each cell takes its lower neighbor and
   // slot 0 takes the pushed entry; otherwise only the addressed cell loads.
   for (genvar g = 0; g < adeq_pkg::DEPTH; g++) begin : g_cell
      logic [adeq_pkg::DATA_W-1:0] prev_q;
      if (g == 0) begin : g_first
         assign prev_q = req_tdata;
      end else begin : g_rest
         assign prev_q = cell_q[g-1];
      end
      adeq_cell u_cell (
         .clock  (clock),
         .shift  (cmd.shift),
         .load   (cmd.write && cmd.wr_idx == adeq_pkg::IDX_W'(g)),
         .prev_q (prev_q),
         .load_d (req_tdata),
         .q      (cell_q[g])
      );
   end

   // Read the slot being popped before this cycle's update lands.
   assign rd_data = cmd.pop_ok ? cell_q[cmd.rd_idx] : '0;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the payload while the consumer stalls.
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_status_ff <= cmd.status;
         rsp_data_ff   <= rd_data;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_fail_gives_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != adeq_pkg::ST_DONE) |-> (rsp_data_ff == '0))
      else $error("failed operation returned nonzero data");

endmodule

// File: rtl/adeq_cell.sv
`timescale 1ns / 1ps
module adeq_cell (
   input  logic                        clock,
   input  logic                        shift,
   input  logic                        load,
   input  logic [adeq_pkg::DATA_W-1:0] prev_q,
   input  logic [adeq_pkg::DATA_W-1:0] load_d,
   output logic [adeq_pkg::DATA_W-1:0] q
);

   logic [adeq_pkg::DATA_W-1:0] data_ff;
   logic [adeq_pkg::DATA_W-1:0] data_in;

   // shift takes the lower neighbor, load takes the pushed entry
   always_comb begin
      data_in = data_ff;
      if (shift) begin
         data_in = prev_q;
      end else if (load) begin
         data_in = load_d;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign q = data_ff;

endmodule

// File: rtl/adeq_ctrl.sv
`timescale 1ns / 1ps
module adeq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  logic [1:0]           mode,
   output adeq_pkg::cmd_type    cmd
);

   logic [adeq_pkg::IDX_W-1:0] head_ff;
   logic [adeq_pkg::IDX_W-1:0] head_in;
   logic [adeq_pkg::IDX_W-1:0] tail_ff;
   logic [adeq_pkg::IDX_W-1:0] tail_in;
   logic                       empty_ff;
   logic                       empty_in;

   always_comb begin
      cmd        = '0;
      cmd.status = adeq_pkg::ST_DONE;
      head_in    = head_ff;
      tail_in    = tail_ff;
      empty_in   = empty_ff;
      unique case (mode) inside
         adeq_pkg::MODE_PUSH_BACK, adeq_pkg::MODE_PUSH_FRONT: begin
            if (empty_ff) begin
               // first entry always lands in slot 0
               cmd.write = 1'b1;
               cmd.wr_idx = '0;
               head_in = '0;
               tail_in = '0;
               empty_in = 1'b0;
            end else if (mode == adeq_pkg::MODE_PUSH_BACK) begin
               if (tail_ff == adeq_pkg::LAST_IDX) begin
                  cmd.status = adeq_pkg::ST_FULL;
               end else begin
                  cmd.write = 1'b1;
                  cmd.wr_idx = tail_ff + 1'b1;
                  tail_in = tail_ff + 1'b1;
               end
            end else if (head_ff == '0) begin
               if (tail_ff == adeq_pkg::LAST_IDX) begin
                  cmd.status = adeq_pkg::ST_FULL;
               end else begin
                  // move the whole row up one slot, new entry enters slot 0
                  cmd.shift = 1'b1;
                  tail_in = tail_ff + 1'b1;
               end
            end else begin
               cmd.write = 1'b1;
               cmd.wr_idx = head_ff - 1'b1;
               head_in = head_ff - 1'b1;
            end
         end
         adeq_pkg::MODE_POP_FRONT, adeq_pkg::MODE_POP_BACK: begin
            cmd.rd_idx = (mode == adeq_pkg::MODE_POP_FRONT) ? head_ff : tail_ff;
            if (empty_ff) begin
               cmd.status = adeq_pkg::ST_EMPTY;
            end else begin
               cmd.pop_ok = 1'b1;
               if (head_ff == tail_ff) begin
                  head_in = '0;
                  tail_in = '0;
                  empty_in = 1'b1;
               end else if (mode == adeq_pkg::MODE_POP_FRONT) begin
                  head_in = head_ff + 1'b1;
               end else begin
                  tail_in = tail_ff - 1'b1;
               end
            end
         end
         default: begin
            cmd.status = adeq_pkg::ST_DONE;
         end
      endcase
      if (!fire) begin
         cmd.shift = 1'b0;
         cmd.write = 1'b0;
         head_in   = head_ff;
         tail_in   = tail_ff;
         empty_in  = empty_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         empty_ff <= 1'b1;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         empty_ff <= empty_in;
      end
   end

   a_empty_at_origin: assert property (@(posedge clock) disable iff (reset)
      empty_ff |-> (head_ff == '0 && tail_ff == '0))
      else $error("empty queue with indices away from slot 0");

   a_head_not_past_tail: assert property (@(posedge clock) disable iff (reset)
      head_ff <= tail_ff)
      else $error("head index passed tail index");

   a_full_keeps_state: assert property (@(posedge clock) disable iff (reset)
      (fire && cmd.status == adeq_pkg::ST_FULL) |=>
         ($stable(head_ff) && $stable(tail_ff) && $stable(empty_ff)))
      else $error("rejected push changed queue state");

endmodule

// File: verif/adeq_checker.sv
`timescale 1ns / 1ps
module adeq_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   output int          fail_count,
   output int          outstanding
);

   typedef struct packed {
      logic [1:0]                  status;
      logic [adeq_pkg::DATA_W-1:0] popped;
   } outcome_type;

   outcome_type                 outcome_q[$];
   logic [adeq_pkg::DATA_W-1:0] slot_mirror[adeq_pkg::DEPTH];
   logic [adeq_pkg::IDX_W-1:0]  head_m;
   logic [adeq_pkg::IDX_W-1:0]  tail_m;
   logic                        empty_m;

   initial begin
      fail_count  = 0;
      outstanding = 0;
      head_m      = '0;
      tail_m      = '0;
      empty_m     = 1'b1;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t adeq_checker: %s got %h want %h", $time, what, got, want);
      fail_count++;
   endtask

   // update the deque mirror for one request beat and return its response
   function automatic outcome_type apply_op(input logic [1:0] mode,
                                            input logic [adeq_pkg::DATA_W-1:0] v);
      outcome_type r;
      int          i;
      r.status = adeq_pkg::ST_DONE;
      r.popped = '0;
      if (empty_m && (mode == adeq_pkg::MODE_PUSH_BACK ||
                      mode == adeq_pkg::MODE_PUSH_FRONT)) begin
         empty_m        = 1'b0;
         head_m         = '0;
         tail_m         = '0;
         slot_mirror[0] = v;
      end else begin
         case (mode)
            adeq_pkg::MODE_PUSH_BACK: begin
               if (tail_m == adeq_pkg::LAST_IDX) begin
                  r.status = adeq_pkg::ST_FULL;
               end else begin
                  tail_m              = tail_m + 1'b1;
                  slot_mirror[tail_m] = v;
               end
            end
            adeq_pkg::MODE_PUSH_FRONT: begin
               if (head_m != '0) begin
                  head_m              = head_m - 1'b1;
                  slot_mirror[head_m] = v;
               end else if (tail_m == adeq_pkg::LAST_IDX) begin
                  r.status = adeq_pkg::ST_FULL;
               end else begin
                  // move every entry up one slot, then write slot zero
                  for (i = int'(tail_m) + 1; i > 0; i--)
                     slot_mirror[i] = slot_mirror[i-1];
                  tail_m         = tail_m + 1'b1;
                  slot_mirror[0] = v;
               end
            end
            default: begin
               if (empty_m) begin
                  r.status = adeq_pkg::ST_EMPTY;
               end else begin
                  r.popped = (mode == adeq_pkg::MODE_POP_FRONT) ? slot_mirror[head_m]
                                                                : slot_mirror[tail_m];
                  if (head_m == tail_m) begin
                     empty_m = 1'b1;
                     head_m  = '0;
                     tail_m  = '0;
                  end else if (mode == adeq_pkg::MODE_POP_FRONT) begin
                     head_m = head_m + 1'b1;
                  end else begin
                     tail_m = tail_m - 1'b1;
                  end
               end
            end
         endcase
      end
      return r;
   endfunction

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         outcome_q.delete();
         head_m  = '0;
         tail_m  = '0;
         empty_m = 1'b1;
      end else begin
         // retire the response first: it belongs to an older request
         if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
            if (outcome_q.size() == 0) begin
               report_mismatch("unexpected response beat", rsp_tdata, '0);
            end else begin
               want = outcome_q.pop_front();
               if (rsp_tuser !== want.status)
                  report_mismatch("status", {30'd0, rsp_tuser}, {30'd0, want.status});
               if (rsp_tdata !== want.popped)
                  report_mismatch("popped_value", rsp_tdata, want.popped);
            end
         end
         if (req_tvalid === 1'b1 && req_tready === 1'b1)
            outcome_q.push_back(apply_op(req_tuser, req_tdata));
      end
      outstanding = outcome_q.size();
   end

endmodule

// File: verif/array_double_ended_queue_unit_test.sv
`timescale 1ns / 1ps
module array_double_ended_queue_unit_test;

   localparam int RANDOM_ITEMS = 1650;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int IDLE_PCT     = 13;
   localparam int LONG_STALL   = 80;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // [31:0] value
   logic [1:0]  req_tuser;   // [1:0] mode
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // [31:0] popped_value
   logic [1:0]  rsp_tuser;   // [1:0] status

   int          fail_count;
   int          outstanding;
   int          cycles;
   int          stall_left;
   bit          quiet;
   bit          long_stall_req;

   array_double_ended_queue_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // watch both channels, predict each response and compare
   adeq_checker watch (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // abort a hung run
   initial cycles = 0;
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("array_double_ended_queue_unit_test: errors");
         $finish;
      end
   end

   // response side: drop tready at random, or hold it low for a long
   // stretch on request so the block backs up and stalls its input
   initial begin
      stall_left     = 0;
      long_stall_req = 1'b0;
      rsp_tready    <= 1'b0;
   end
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (long_stall_req) begin
         long_stall_req = 1'b0;
         stall_left     = LONG_STALL;
         rsp_tready    <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // offer one request beat, with random idle cycles ahead of it, and
   // hold it until it is taken
   task automatic send_beat(input logic [1:0] mode, input logic [31:0] value);
      while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= value;
      @(posedge clock);
      while (req_tready !== 1'b1)
         @(posedge clock);
   endtask

   // stop offering and wait until every predicted response has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
   endtask

   initial begin
      int          k;
      int          n;
      int          seg_left;
      int          push_pct;
      int          front_pct;
      bit          is_push;
      bit          is_front;
      logic [1:0]  mode;
      logic [31:0] value;

      quiet      = 1'b0;
      seg_left   = 0;
      push_pct   = 50;
      front_pct  = 50;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= adeq_pkg::MODE_PUSH_BACK;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: empty pops, extreme values, front push with shift,
      // popping the only entry, fill to full, full pushes both ways,
      // back push refused with free slots in front, front push with head up
      send_beat(adeq_pkg::MODE_POP_FRONT,  32'hdead_beef);
      send_beat(adeq_pkg::MODE_POP_BACK,   32'h1234_5678);
      send_beat(adeq_pkg::MODE_PUSH_BACK,  32'h8000_0000);
      send_beat(adeq_pkg::MODE_PUSH_FRONT, 32'h7fff_ffff);
      send_beat(adeq_pkg::MODE_POP_BACK,   32'h0000_0000);
      send_beat(adeq_pkg::MODE_POP_FRONT,  32'h0000_0000);
      send_beat(adeq_pkg::MODE_PUSH_FRONT, 32'hffff_ffff);
      for (k = 0; k < adeq_pkg::DEPTH - 1; k++)
         send_beat(adeq_pkg::MODE_PUSH_BACK,
                   k[0] ? 32'haaaa_aaaa : (32'h5555_5555 ^ k));
      send_beat(adeq_pkg::MODE_PUSH_BACK,  32'h0000_0000);
      send_beat(adeq_pkg::MODE_PUSH_FRONT, 32'h0000_0001);
      send_beat(adeq_pkg::MODE_POP_FRONT,  32'h0000_0000);
      send_beat(adeq_pkg::MODE_POP_FRONT,  32'h0000_0000);
      send_beat(adeq_pkg::MODE_PUSH_BACK,  32'h0000_0002);
      send_beat(adeq_pkg::MODE_PUSH_FRONT, 32'h0000_0003);

      // random: segments biased toward pushes or pops so the queue swings
      // between empty and full, each with its own front/back preference
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (seg_left == 0) begin
            seg_left = $urandom_range(8, 48);
            case ($urandom_range(0, 2))
               0:       push_pct = 85;
               1:       push_pct = 50;
               default: push_pct = 15;
            endcase
            front_pct = $urandom_range(0, 100);
         end
         seg_left--;
         quiet = (n >= 500 && n < 800);
         if (n == 300)
            long_stall_req = 1'b1;
         if (n == 1100)
            drain();
         is_push  = ($urandom_range(0, 99) < push_pct);
         is_front = ($urandom_range(0, 99) < front_pct);
         if (is_push)
            mode = is_front ? adeq_pkg::MODE_PUSH_FRONT : adeq_pkg::MODE_PUSH_BACK;
         else
            mode = is_front ? adeq_pkg::MODE_POP_FRONT : adeq_pkg::MODE_POP_BACK;
         case ($urandom_range(0, 9))
            0:       value = 32'h8000_0000;
            1:       value = 32'h7fff_ffff;
            2:       value = 32'hffff_ffff;
            3:       value = 32'h0000_0000;
            default: value = $urandom;
         endcase
         send_beat(mode, value);
      end

      drain();
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("array_double_ended_queue_unit_test: clean");
      else
         $display("array_double_ended_queue_unit_test: errors");
      $finish;
   end

endmodule
